@@ sv/char_lcd_nibble_writer_core_assert.svh @@
// Assertion macros shared by the character LCD writer modules.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition that holds at every clock edge out of reset
`define CNW_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("cnw: invariant violated");
// antecedent in one cycle implies consequent in the next
`define CNW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnw: sequence violated");
`else
`define CNW_ASSERT_ALWAYS(lbl, expr)
`define CNW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/cnw_pkg.sv @@
// Types, constants and lookup tables for the character LCD nibble writer.
// No dependencies; used by all cnw modules and the core top level.
`default_nettype none
package cnw_pkg;

  // glyph store sizing
  localparam int unsigned GLYPH_COUNT = 5;
  localparam int unsigned GLYPH_ROWS  = 8;
  localparam int unsigned BIDX_W      = $clog2(GLYPH_ROWS + 1);

  // job queue sizing
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_POWER = 2'd2;
  localparam logic [1:0] OP_GLYPH = 2'd3;

  // register indexes (selected by address bit 2)
  localparam logic REG_PULSE_HOLD = 1'b0;
  localparam logic REG_POWER_WAIT = 1'b1;
  localparam logic [7:0] PULSE_HOLD_RST = 8'd5;
  localparam logic [7:0] POWER_WAIT_RST = 8'd15;

  // UTF-8 handling
  localparam logic [7:0] LEAD_BYTE  = 8'hC3;
  localparam logic [7:0] ACC_A_AC   = 8'hA1;
  localparam logic [7:0] ACC_E_AC   = 8'hA9;
  localparam logic [7:0] ACC_C_CED  = 8'hA7;
  localparam logic [7:0] ACC_A_TIL  = 8'hA3;
  localparam logic [7:0] ACC_O_TIL  = 8'hB5;

  // panel commands
  localparam logic [7:0] CMD_CGRAM_BASE = 8'h40;
  localparam logic [3:0] POWER_NIBBLE   = 4'h2;
  localparam logic [7:0] POWER_CMDS [0:3] = '{8'h28, 8'h0C, 8'h06, 8'h01};

  // accent bitmaps, rows top to bottom
  localparam logic [7:0] GLYPH_ROM [0:7][0:7] = '{
    '{8'h02, 8'h04, 8'h0E, 8'h01, 8'h0F, 8'h11, 8'h0F, 8'h00},
    '{8'h02, 8'h04, 8'h0E, 8'h11, 8'h1F, 8'h10, 8'h0E, 8'h00},
    '{8'h00, 8'h0F, 8'h10, 8'h10, 8'h0F, 8'h02, 8'h0E, 8'h00},
    '{8'h0D, 8'h12, 8'h06, 8'h01, 8'h0F, 8'h11, 8'h0F, 8'h00},
    '{8'h0D, 8'h12, 8'h00, 8'h0E, 8'h11, 8'h11, 8'h0E, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic [7:0] hold_ms;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_POWER,
    JOB_GLYPH
  } job_kind_t;

  // classified work handed from front to back
  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } accent_t;

  // second byte of a 0xC3 sequence to custom character code
  function automatic accent_t map_accent(logic [7:0] b);
    accent_t a;
    a.hit  = 1'b1;
    a.code = 8'd0;
    unique case (b)
      ACC_A_AC:  a.code = 8'd0;
      ACC_E_AC:  a.code = 8'd1;
      ACC_C_CED: a.code = 8'd2;
      ACC_A_TIL: a.code = 8'd3;
      ACC_O_TIL: a.code = 8'd4;
      default:   a.hit  = 1'b0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ sv/char_lcd_nibble_writer_core.sv @@
// Character LCD 4-bit pin sequencer, usage notes:
//  in_push/in_full: push an item {opcode, byte_value} when in_full is low.
//  out_empty/out_pop: each result is one pin state {reg_select, enable_pin,
//   data_nibble, hold_ms, last}; last marks the final state of an item.
//  cfg_*: APB write/read of pulse_hold_ms (addr 0) and power_wait_ms (addr 4).
// A sent byte gives 4 results, power-on 19, glyph load 36; a held lead byte,
// a zero text byte or a bad glyph index give none.
// Path: an accepted item enters the job queue, then the back end registers
// its results in the output register. Throughput: one result per cycle from
// the back-end sequencer while out_pop keeps up; the two-entry job queue lets
// the front accept items while the back end is still expanding earlier ones.
// Reset: registers return to 5 ms / 15 ms, lead byte state and queue clear,
// no result pending. No clearing pass is needed.
// When the receiver stalls (out_pop low), the result is held, the sequencer
// stops, and in_full rises once the job queue fills.
// Depends on cnw_pkg, cnw_front, cnw_queue, cnw_back.
`default_nettype none
module char_lcd_nibble_writer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire cnw_pkg::in_item_t  in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output cnw_pkg::out_item_t      out_item,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic          pulse_hold_wr, power_wait_wr;
  logic [7:0]    pulse_hold_ms_r, power_wait_ms_r;
  logic          cfg_wr;
  logic          q_push, q_full, q_pop, q_valid;
  cnw_pkg::job_t push_job, head_job;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign pulse_hold_wr = cfg_wr && (cfg_paddr[2] == cnw_pkg::REG_PULSE_HOLD);
  assign power_wait_wr = cfg_wr && (cfg_paddr[2] == cnw_pkg::REG_POWER_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_hold_ms_r <= cnw_pkg::PULSE_HOLD_RST;
      power_wait_ms_r <= cnw_pkg::POWER_WAIT_RST;
    end else begin
      if (pulse_hold_wr) pulse_hold_ms_r <= cfg_pwdata[7:0];
      if (power_wait_wr) power_wait_ms_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = {24'd0, (cfg_paddr[2] == cnw_pkg::REG_POWER_WAIT) ?
                              power_wait_ms_r : pulse_hold_ms_r};

  cnw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_job    (push_job),
    .q_full   (q_full)
  );

  cnw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  cnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pulse_hold (pulse_hold_ms_r),
    .power_wait (power_wait_ms_r),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

@@ sv/cnw_front.sv @@
// Front end: accepts items, tracks the UTF-8 lead byte, classifies into jobs.
// Depends on cnw_pkg.
`default_nettype none
module cnw_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire cnw_pkg::in_item_t in_item,
  output logic                  q_push,
  output cnw_pkg::job_t         q_job,
  input  wire logic             q_full
);

  logic             lead_r, lead_nxt;
  logic             accept;
  logic             job_ok;
  cnw_pkg::accent_t acc;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && job_ok;

  // classify one item
  always_comb begin
    acc      = cnw_pkg::map_accent(in_item.byte_value);
    lead_nxt = 1'b0;
    job_ok   = 1'b0;
    q_job.kind  = cnw_pkg::JOB_BYTE;
    q_job.rs    = 1'b0;
    q_job.value = in_item.byte_value;
    unique case (in_item.opcode)
      cnw_pkg::OP_TEXT: begin
        q_job.rs = 1'b1;
        if (lead_r && acc.hit) begin
          job_ok      = 1'b1;
          q_job.value = acc.code;
        end else if (in_item.byte_value == cnw_pkg::LEAD_BYTE) begin
          lead_nxt = 1'b1;
        end else if (in_item.byte_value != 8'd0) begin
          job_ok = 1'b1;
        end
      end
      cnw_pkg::OP_CMD: begin
        job_ok = 1'b1;
      end
      cnw_pkg::OP_POWER: begin
        job_ok     = 1'b1;
        q_job.kind = cnw_pkg::JOB_POWER;
      end
      default: begin
        q_job.kind = cnw_pkg::JOB_GLYPH;
        job_ok     = (in_item.byte_value < 8'(cnw_pkg::GLYPH_COUNT));
      end
    endcase
  end

  // lead byte state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 1'b0;
    end else if (accept) begin
      lead_r <= lead_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/cnw_queue.sv @@
// Short job queue between front and back end.
// Depends on cnw_pkg and the assertion macro header.
`default_nettype none
`include "char_lcd_nibble_writer_core_assert.svh"
module cnw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cnw_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output cnw_pkg::job_t      head_job
);

  cnw_pkg::job_t                   mem_r [cnw_pkg::Q_DEPTH];
  logic [cnw_pkg::Q_PTR_W-1:0]     wr_r, rd_r;
  logic [cnw_pkg::Q_CNT_W-1:0]     cnt_r;

  assign full       = (cnt_r == cnw_pkg::Q_CNT_W'(cnw_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  `CNW_ASSERT_ALWAYS(a_q_no_overflow, !(push && full && !pop))
  `CNW_ASSERT_ALWAYS(a_q_pop_nonempty, !pop || head_valid)
  `CNW_ASSERT_NEXT(a_q_push_fills, push && !pop, head_valid)

endmodule
`default_nettype wire

@@ sv/cnw_back.sv @@
// Back end: expands each job into pin-state items, one per cycle unless out_pop stalls the output.
// Depends on cnw_pkg and the assertion macro header.
`default_nettype none
`include "char_lcd_nibble_writer_core_assert.svh"
module cnw_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    pulse_hold,
  input  wire logic [7:0]    power_wait,
  input  wire logic          q_valid,
  input  wire cnw_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output cnw_pkg::out_item_t out_item
);

  logic [cnw_pkg::BIDX_W-1:0] bidx_r, last_bidx;
  logic [1:0]                 ph_r;
  logic [1:0]                 pre_cnt_r;
  logic                       pre_done_r;
  logic                       out_valid_r;
  cnw_pkg::out_item_t         out_item_r, res;
  logic                       in_pre, advance;
  logic [7:0]                 cur_byte;
  logic                       cur_rs;
  logic [2:0]                 row;

  assign in_pre    = (q_job.kind == cnw_pkg::JOB_POWER) && !pre_done_r;
  assign advance   = q_valid && (!out_valid_r || out_pop);
  assign q_pop     = advance && res.last;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign row       = 3'(bidx_r - 1'b1);

  // byte currently being sent
  always_comb begin
    cur_byte  = q_job.value;
    cur_rs    = q_job.rs;
    last_bidx = '0;
    unique case (q_job.kind)
      cnw_pkg::JOB_POWER: begin
        cur_byte  = cnw_pkg::POWER_CMDS[bidx_r[1:0]];
        cur_rs    = 1'b0;
        last_bidx = cnw_pkg::BIDX_W'(3);
      end
      cnw_pkg::JOB_GLYPH: begin
        last_bidx = cnw_pkg::BIDX_W'(cnw_pkg::GLYPH_ROWS);
        if (bidx_r == '0) begin
          cur_byte = cnw_pkg::CMD_CGRAM_BASE + {2'b00, q_job.value[2:0], 3'b000};
          cur_rs   = 1'b0;
        end else begin
          cur_byte = cnw_pkg::GLYPH_ROM[q_job.value[2:0]][row];
          cur_rs   = 1'b1;
        end
      end
      default: begin
        last_bidx = '0;
      end
    endcase
  end

  // pin state for this step
  always_comb begin
    res.reg_select  = cur_rs;
    res.enable_pin  = !ph_r[0];
    res.data_nibble = ph_r[1] ? cur_byte[3:0] : cur_byte[7:4];
    res.hold_ms     = ph_r[0] ? 8'd0 : pulse_hold;
    res.last        = (ph_r == 2'd3) && (bidx_r == last_bidx);
    if (in_pre) begin
      res.reg_select = 1'b0;
      res.last       = 1'b0;
      case (pre_cnt_r)
        2'd0: begin
          res.enable_pin  = 1'b0;
          res.data_nibble = 4'h0;
          res.hold_ms     = power_wait;
        end
        2'd1: begin
          res.enable_pin  = 1'b1;
          res.data_nibble = cnw_pkg::POWER_NIBBLE;
          res.hold_ms     = pulse_hold;
        end
        default: begin
          res.enable_pin  = 1'b0;
          res.data_nibble = cnw_pkg::POWER_NIBBLE;
          res.hold_ms     = 8'd0;
        end
      endcase
    end
  end

  // step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidx_r     <= '0;
      ph_r       <= '0;
      pre_cnt_r  <= '0;
      pre_done_r <= 1'b0;
    end else if (advance) begin
      if (in_pre) begin
        if (pre_cnt_r == 2'd2) begin
          pre_cnt_r  <= '0;
          pre_done_r <= 1'b1;
        end else begin
          pre_cnt_r <= pre_cnt_r + 1'b1;
        end
      end else begin
        ph_r <= ph_r + 1'b1;
        if (res.last) begin
          bidx_r     <= '0;
          pre_done_r <= 1'b0;
        end else if (ph_r == 2'd3) begin
          bidx_r <= bidx_r + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item_r <= res;
  end

  `CNW_ASSERT_ALWAYS(a_bidx_range, bidx_r <= cnw_pkg::BIDX_W'(cnw_pkg::GLYPH_ROWS))
  `CNW_ASSERT_ALWAYS(a_pre_phase_idle, !in_pre || (ph_r == 2'd0 && pre_cnt_r != 2'd3))
  `CNW_ASSERT_NEXT(a_out_held, out_valid_r && !out_pop, out_valid_r)
  `CNW_ASSERT_NEXT(a_pop_restarts, q_pop, bidx_r == '0 && ph_r == 2'd0)

endmodule
`default_nettype wire
